// ===== hw/rtl/gcol_pkg.sv =====
package gcol_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int RESULT_CAP = 16;
  localparam int ROW_W = 16;
  localparam int CNT_W = 5;
  localparam int COLOR_W = 4;
  localparam int VTX_W = 4;
  localparam int DEG_W = 5;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;
  localparam logic [COLOR_W-1:0] COLOR_LIMIT_RESET = 4'd3;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_LIMIT = 2'd1;

  typedef struct packed {
    logic start;
    logic asg;
    logic fresh;
    logic [COLOR_W-1:0] color;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/greedy_graph_coloring.sv =====
// The block accepts a row every cycle until the graph is complete, then holds in_stall high.
// After the last of n rows: a setup step, then per color round a degree search over n vertices,
// an assignment step and a conflict scan; rounds stop at color_limit (none if it is zero) or
// when no uncolored vertex is left. Then n result words, one per cycle unless out_stall holds.
// Synchronous active-high reset restores vertex_count 16 and color_limit 3 and empties the load.
module greedy_graph_coloring #(
  parameter int MAX_VERTICES = gcol_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_en,
  input  logic [gcol_pkg::CFG_IDX_W-1:0]      write_index,
  input  logic [gcol_pkg::CFG_W-1:0]          write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gcol_pkg::ROW_W-1:0]          row_bits,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gcol_pkg::VTX_W-1:0]          vertex,
  output logic [gcol_pkg::COLOR_W-1:0]        color,
  output logic                                last_vertex
);

  localparam int LANES = (MAX_VERTICES < gcol_pkg::RESULT_CAP) ?
                         MAX_VERTICES : gcol_pkg::RESULT_CAP;
  localparam int IDX_W = $clog2(LANES);

  logic [gcol_pkg::CNT_W-1:0] vertex_count;
  logic [gcol_pkg::COLOR_W-1:0] color_limit;
  logic [LANES-1:0] rows [LANES];
  logic [LANES-1:0] cols [LANES];
  logic [LANES-1:0] mask;
  logic [LANES-1:0][gcol_pkg::COLOR_W-1:0] colors;
  logic [LANES-1:0][gcol_pkg::DEG_W-1:0] degrees;
  logic [LANES-1:0] blocked;
  logic [IDX_W-1:0] load_idx;
  logic [gcol_pkg::CNT_W-1:0] n_act;
  gcol_pkg::lane_ctl_t ctl;
  logic [IDX_W-1:0] sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gcol_pkg::VERTEX_COUNT_RESET;
      color_limit <= gcol_pkg::COLOR_LIMIT_RESET;
    end else if (write_en) begin
      case (write_index)
        gcol_pkg::REG_VERTEX_COUNT: vertex_count <= write_data[gcol_pkg::CNT_W-1:0];
        gcol_pkg::REG_COLOR_LIMIT: color_limit <= write_data[gcol_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rows[load_idx] <= row_bits[LANES-1:0];
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      mask[j] = (gcol_pkg::CNT_W'(j) < n_act);
    end
    for (int k = 0; k < LANES; k++) begin
      for (int j = 0; j < LANES; j++) begin
        cols[k][j] = rows[j][k];
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    gcol_lane #(
      .LANES   (LANES),
      .LANE_ID (k),
      .IDX_W   (IDX_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .row     (rows[k]),
      .col     (cols[k]),
      .mask    (mask),
      .ctl     (ctl),
      .sel     (sel),
      .color   (colors[k]),
      .degree  (degrees[k]),
      .blocked (blocked[k])
    );
  end

  gcol_seq #(
    .LANES (LANES),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vertex_count (vertex_count),
    .color_limit  (color_limit),
    .colors       (colors),
    .degrees      (degrees),
    .blocked      (blocked),
    .load_idx     (load_idx),
    .n_act        (n_act),
    .ctl          (ctl),
    .sel          (sel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex       (vertex),
    .color        (color),
    .last_vertex  (last_vertex)
  );

endmodule

// ===== hw/rtl/gcol_lane.sv =====
module gcol_lane #(
  parameter int LANES = 16,
  parameter int LANE_ID = 0,
  parameter int IDX_W = $clog2(LANES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [LANES-1:0]              row,
  input  logic [LANES-1:0]              col,
  input  logic [LANES-1:0]              mask,
  input  gcol_pkg::lane_ctl_t           ctl,
  input  logic [IDX_W-1:0]              sel,
  output logic [gcol_pkg::COLOR_W-1:0]  color,
  output logic [gcol_pkg::DEG_W-1:0]    degree,
  output logic                          blocked
);

  logic [LANES-1:0] self_bit;
  logic [LANES-1:0] own;
  logic [LANES-1:0] sym;
  logic [gcol_pkg::DEG_W-1:0] cnt;

  always_comb begin
    self_bit = LANES'(1) << LANE_ID;
    own = row & mask & ~self_bit;
    sym = (row | col) & mask & ~self_bit;
    cnt = '0;
    for (int j = 0; j < LANES; j++) begin
      cnt = cnt + gcol_pkg::DEG_W'(own[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= '0;
      blocked <= 1'b0;
      degree <= '0;
    end else if (ctl.start) begin
      color <= '0;
      blocked <= 1'b0;
      degree <= cnt;
    end else if (ctl.asg) begin
      if (sel == IDX_W'(LANE_ID)) begin
        color <= ctl.color;
      end
      blocked <= (ctl.fresh ? 1'b0 : blocked) | sym[sel];
    end
  end

endmodule

// ===== hw/rtl/gcol_seq.sv =====
module gcol_seq #(
  parameter int LANES = 16,
  parameter int IDX_W = $clog2(LANES)
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [gcol_pkg::CNT_W-1:0]                vertex_count,
  input  logic [gcol_pkg::COLOR_W-1:0]              color_limit,
  input  logic [LANES-1:0][gcol_pkg::COLOR_W-1:0]   colors,
  input  logic [LANES-1:0][gcol_pkg::DEG_W-1:0]     degrees,
  input  logic [LANES-1:0]                          blocked,
  output logic [IDX_W-1:0]                          load_idx,
  output logic [gcol_pkg::CNT_W-1:0]                n_act,
  output gcol_pkg::lane_ctl_t                       ctl,
  output logic [IDX_W-1:0]                          sel,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [gcol_pkg::VTX_W-1:0]                vertex,
  output logic [gcol_pkg::COLOR_W-1:0]              color,
  output logic                                      last_vertex
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_PICKED = 3'd3;
  localparam logic [2:0] S_COLOR  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [gcol_pkg::CNT_W-1:0] rows_loaded;
  logic [gcol_pkg::CNT_W-1:0] rows_next;
  logic [gcol_pkg::CNT_W-1:0] n_cfg;
  logic [gcol_pkg::CNT_W-1:0] n_m1;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] pick;
  logic [gcol_pkg::DEG_W-1:0] best;
  logic found;
  logic [gcol_pkg::COLOR_W-1:0] round;
  logic last_idx;
  logic cur_free;
  logic better;
  logic out_load;

  always_comb begin
    if (vertex_count == '0) begin
      n_cfg = gcol_pkg::CNT_W'(1);
    end else if (vertex_count > gcol_pkg::CNT_W'(LANES)) begin
      n_cfg = gcol_pkg::CNT_W'(LANES);
    end else begin
      n_cfg = vertex_count;
    end
    rows_next = rows_loaded + 1'b1;
    n_m1 = n_act - 1'b1;
    last_idx = (idx == n_m1[IDX_W-1:0]);
    cur_free = (colors[idx] == '0);
    better = cur_free && (!found || degrees[idx] > best);
    out_load = (state == S_OUT) && (!out_valid || !out_stall);
  end

  assign in_stall = (state != S_LOAD);
  assign load_idx = rows_loaded[IDX_W-1:0];

  always_comb begin
    ctl = '0;
    sel = idx;
    ctl.color = round;
    case (state)
      S_START: begin
        ctl.start = 1'b1;
      end
      S_PICKED: begin
        ctl.asg = found;
        ctl.fresh = 1'b1;
        sel = pick;
      end
      S_COLOR: begin
        ctl.asg = cur_free && !blocked[idx];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      rows_loaded <= '0;
      n_act <= gcol_pkg::CNT_W'(LANES);
      idx <= '0;
      found <= 1'b0;
      round <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (rows_next >= n_cfg) begin
              rows_loaded <= '0;
              n_act <= n_cfg;
              state <= S_START;
            end else begin
              rows_loaded <= rows_next;
            end
          end
        end
        S_START: begin
          idx <= '0;
          round <= gcol_pkg::COLOR_W'(1);
          found <= 1'b0;
          state <= (color_limit == '0) ? S_OUT : S_PICK;
        end
        S_PICK: begin
          if (better) begin
            found <= 1'b1;
            best <= degrees[idx];
            pick <= idx;
          end
          if (last_idx) begin
            idx <= '0;
            state <= S_PICKED;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_PICKED: begin
          found <= 1'b0;
          state <= found ? S_COLOR : S_OUT;
        end
        S_COLOR: begin
          if (last_idx) begin
            idx <= '0;
            if (round == color_limit) begin
              state <= S_OUT;
            end else begin
              round <= round + 1'b1;
              state <= S_PICK;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (last_idx) begin
              idx <= '0;
              state <= S_LOAD;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex <= gcol_pkg::VTX_W'(idx);
      color <= colors[idx];
      last_vertex <= last_idx;
    end
  end

endmodule

// ===== tb/greedy_graph_coloring_tb.sv =====
`timescale 1ns / 1ps

module greedy_graph_coloring_tb;

  localparam int MAX_V = gcol_pkg::MAX_VERTICES_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ROWS = 450;
  localparam logic [gcol_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gcol_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [gcol_pkg::VTX_W-1:0] vertex;
    logic [gcol_pkg::COLOR_W-1:0] color;
    logic last;
  } color_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_en = 1'b0;
  logic [gcol_pkg::CFG_IDX_W-1:0] write_index = '0;
  logic [gcol_pkg::CFG_W-1:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [gcol_pkg::ROW_W-1:0] row_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [gcol_pkg::VTX_W-1:0] vertex;
  logic [gcol_pkg::COLOR_W-1:0] color;
  logic last_vertex;

  logic [gcol_pkg::ROW_W-1:0] row_queue[$];
  color_word_t due_words[$];
  logic [gcol_pkg::ROW_W-1:0] adj_rows[MAX_V];
  logic [gcol_pkg::CNT_W-1:0] shadow_vertex_count = gcol_pkg::VERTEX_COUNT_RESET;
  logic [gcol_pkg::COLOR_W-1:0] shadow_color_limit = gcol_pkg::COLOR_LIMIT_RESET;
  int rows_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;

  greedy_graph_coloring i_dut (
    .clk(clk),
    .rst(rst),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .row_bits(row_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .vertex(vertex),
    .color(color),
    .last_vertex(last_vertex)
  );

  always #5 clk = ~clk;

  function automatic int active_vertices();
    int n;
    n = int'(shadow_vertex_count);
    if (n < 1) n = 1;
    if (n > MAX_V) n = MAX_V;
    return n;
  endfunction

  function automatic bit adjacent(int a, int b);
    if (a == b) return 1'b0;
    return adj_rows[a][b] || adj_rows[b][a];
  endfunction

  // Stores one row and, when the graph is complete, colors it and queues one word per vertex.
  function automatic void take_row(input logic [gcol_pkg::ROW_W-1:0] r);
    int n;
    int pick;
    int best;
    int deg[MAX_V];
    logic [gcol_pkg::COLOR_W-1:0] col[MAX_V];
    bit clash;
    color_word_t w;
    n = active_vertices();
    if (rows_seen < MAX_V) adj_rows[rows_seen] = r;
    rows_seen = (rows_seen + 1) % 32;
    if (rows_seen < n) return;
    for (int i = 0; i < n; i++) begin
      deg[i] = 0;
      col[i] = '0;
      for (int k = 0; k < n; k++)
        if (k != i && adj_rows[i][k]) deg[i]++;
    end
    for (int c = 1; c <= int'(shadow_color_limit); c++) begin
      pick = n;
      best = 0;
      for (int i = 0; i < n; i++) begin
        if (col[i] == 0 && (pick == n || deg[i] > best)) begin
          pick = i;
          best = deg[i];
        end
      end
      if (pick == n) break;
      col[pick] = gcol_pkg::COLOR_W'(c);
      for (int i = 0; i < n; i++) begin
        if (col[i] == 0) begin
          clash = 1'b0;
          for (int k = 0; k < n; k++)
            if (col[k] == gcol_pkg::COLOR_W'(c) && adjacent(i, k)) clash = 1'b1;
          if (!clash) col[i] = gcol_pkg::COLOR_W'(c);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      w.vertex = gcol_pkg::VTX_W'(i);
      w.color = col[i];
      w.last = (i == n - 1);
      due_words.push_back(w);
    end
    rows_seen = 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_word(input logic [gcol_pkg::VTX_W-1:0] v,
                            input logic [gcol_pkg::COLOR_W-1:0] c,
                            input logic l);
    color_word_t w;
    if (due_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word vertex %0d color %0d last %0b", v, c, l));
      return;
    end
    w = due_words.pop_front();
    if (v !== w.vertex)
      report_mismatch($sformatf("vertex %0d, expected %0d", v, w.vertex));
    if (c !== w.color)
      report_mismatch($sformatf("vertex %0d color %0d, expected %0d", w.vertex, c, w.color));
    if (l !== w.last)
      report_mismatch($sformatf("vertex %0d last_vertex %0b, expected %0b", w.vertex, l, w.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) take_row(row_bits);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (row_queue.size() != 0) begin
          in_valid <= 1'b1;
          row_bits <= row_queue.pop_front();
          send_gap <= gaps_on ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_word(vertex, color, last_vertex);
      stall_draw = stalls_on ? $urandom_range(0, 3) : 0;
      out_stall <= (stall_draw != 0);
      stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!out_valid) begin
      out_stall <= stalls_on && ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** greedy_graph_coloring: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [gcol_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcol_pkg::CFG_W-1:0] data);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_en <= 1'b0;
    case (idx)
      gcol_pkg::REG_VERTEX_COUNT: shadow_vertex_count = data;
      gcol_pkg::REG_COLOR_LIMIT: shadow_color_limit = data[gcol_pkg::COLOR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (row_queue.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [gcol_pkg::ROW_W-1:0] random_row();
    case ($urandom_range(0, 4))
      0: return gcol_pkg::ROW_W'($urandom);
      1: return gcol_pkg::ROW_W'($urandom & $urandom & $urandom);
      2: return gcol_pkg::ROW_W'($urandom | $urandom);
      3: return $urandom_range(0, 1) ? '1 : '0;
      default: return gcol_pkg::ROW_W'(1) << $urandom_range(0, gcol_pkg::ROW_W - 1);
    endcase
  endfunction

  task automatic queue_random_rows(input int count);
    repeat (count) row_queue.push_back(random_row());
  endtask

  initial begin
    int random_rows;
    int phase;
    int n;
    int split;
    int need;
    logic [gcol_pkg::CNT_W-1:0] edge_counts[6];
    logic [gcol_pkg::CFG_W-1:0] edge_limits[6];
    edge_counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17};
    edge_limits = '{5'd15, 5'd1, 5'd0, 5'h1F, 5'd7, 5'd15};
    random_rows = 0;
    phase = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: sixteen vertices, three colors.
    row_queue = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'hAAAA, 16'h5555, 16'h0000,
                  16'h0000, 16'h00F0, 16'h0F00, 16'h0000, 16'hFFFF, 16'h0000, 16'h1234,
                  16'h0000, 16'h0003};
    drain();

    // A vertex count of zero acts as one; a color limit of zero leaves everything uncolored.
    write_reg(gcol_pkg::REG_VERTEX_COUNT, 5'd0);
    write_reg(gcol_pkg::REG_COLOR_LIMIT, 5'd0);
    row_queue.push_back(16'hFFFF);
    drain();

    // One-sided edge, and writes to unused indexes that must change nothing.
    write_reg(gcol_pkg::REG_VERTEX_COUNT, 5'd2);
    write_reg(gcol_pkg::REG_COLOR_LIMIT, 5'h1F);
    write_reg(REG_SPARE_A, 5'd9);
    write_reg(REG_SPARE_B, 5'd31);
    row_queue = '{16'h0002, 16'h0000};
    drain();

    // No edges: the one round that the color limit allows colors everything.
    write_reg(gcol_pkg::REG_VERTEX_COUNT, 5'd3);
    write_reg(gcol_pkg::REG_COLOR_LIMIT, 5'd1);
    row_queue = '{16'hFFF8, 16'h0002, 16'h0000};
    drain();

    // Vertex count lowered in the middle of a load.
    write_reg(gcol_pkg::REG_VERTEX_COUNT, 5'd4);
    row_queue = '{16'h0006, 16'h0001, 16'h0001};
    drain();
    write_reg(gcol_pkg::REG_VERTEX_COUNT, 5'd2);
    row_queue.push_back(16'h0008);
    drain();

    while (random_rows < RANDOM_ROWS) begin
      gaps_on = ($urandom_range(0, 2) != 0);
      stalls_on = ($urandom_range(0, 2) != 0);
      if (phase < 6) begin
        write_reg(gcol_pkg::REG_VERTEX_COUNT, edge_counts[phase]);
        write_reg(gcol_pkg::REG_COLOR_LIMIT, edge_limits[phase]);
      end else if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0)
          write_reg(gcol_pkg::REG_VERTEX_COUNT,
                    $urandom_range(0, 1) ? 5'd0 : gcol_pkg::CFG_W'($urandom_range(17, 31)));
        else
          write_reg(gcol_pkg::REG_VERTEX_COUNT, gcol_pkg::CFG_W'($urandom_range(1, 16)));
        if ($urandom_range(0, 7) == 0)
          write_reg(gcol_pkg::REG_COLOR_LIMIT, gcol_pkg::CFG_W'($urandom_range(0, 31)));
        else
          write_reg(gcol_pkg::REG_COLOR_LIMIT, gcol_pkg::CFG_W'($urandom_range(1, 15)));
      end
      repeat ($urandom_range(1, 3)) begin
        n = active_vertices();
        if (n > 1 && $urandom_range(0, 7) == 0) begin
          split = $urandom_range(1, n - 1);
          queue_random_rows(split);
          drain();
          write_reg(gcol_pkg::REG_VERTEX_COUNT, gcol_pkg::CFG_W'($urandom_range(1, 16)));
          n = active_vertices();
          need = (n > rows_seen) ? n - rows_seen : 1;
          queue_random_rows(need);
          random_rows += split + need;
        end else begin
          queue_random_rows(n);
          random_rows += n;
        end
      end
      drain();
      phase++;
    end

    gaps_on = 1'b0;
    stalls_on = 1'b0;
    drain();
    repeat (600) @(posedge clk);
    if (due_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", due_words.size()));
    if (fail_count == 0)
      $display("** greedy_graph_coloring: PASSED **");
    else
      $display("** greedy_graph_coloring: FAILED **");
    $finish;
  end

endmodule
